// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during reset.
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/immp_pkg.sv
`timescale 1ns / 1ps

package immp_pkg;

  localparam int CH_W  = 4;
  localparam int TS_W  = 32;
  localparam int EXT_W = 9;

  localparam logic [TS_W-1:0] MIN_RESET = 32'h0000_FFFF;
  localparam logic [TS_W-1:0] TMAX_RESET = 32'hFFFF_FFFF;
  localparam logic            REQ_START = 1'b0;
  localparam logic            REQ_END   = 1'b1;

  typedef struct packed {
    logic            req_type;
    logic [CH_W-1:0] channel;
    logic [TS_W-1:0] timestamp;
  } in_req_t;

  typedef struct packed {
    logic [CH_W-1:0] channel_out;
    logic [TS_W-1:0] interval;
    logic [TS_W-1:0] min_interval;
    logic [TS_W-1:0] max_interval;
  } out_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SPAN,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic accept;
    logic ld_span;
    logic ld_out;
  } cmd_t;

  typedef struct packed {
    logic end_hit;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/immp_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module immp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  immp_pkg::sts_t sts,
  output immp_pkg::cmd_t cmd
);
  import immp_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
        if (in_valid && sts.end_hit) begin
          state_nxt = ST_SPAN;
        end
      end
      ST_SPAN: begin
        cmd.ld_span = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // end event waits in update until the result register has room
  `AST_NXT(a_upd_hold, (state_r == ST_UPD) && !sts.out_free, state_r == ST_UPD)
  // nothing starts without an accepted request
  `AST_NXT(a_idle_stay, (state_r == ST_IDLE) && !cmd.accept, state_r == ST_IDLE)

endmodule

// File: rtl/immp_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module immp_dp #(
  parameter int CHANNELS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  immp_pkg::in_req_t         in_req,
  input  logic                      cfg_we,
  input  logic [immp_pkg::TS_W-1:0] cfg_wdata,
  input  immp_pkg::cmd_t            cmd,
  output immp_pkg::sts_t            sts,
  output logic                      out_valid,
  input  logic                      out_stall,
  output immp_pkg::out_res_t        out_res
);
  import immp_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [TS_W-1:0] start_mem [CHANNELS];
  logic [TS_W-1:0] min_mem   [CHANNELS];
  logic [TS_W-1:0] max_mem   [CHANNELS];

  logic [CHANNELS-1:0] sv_vld_r;
  logic [CHANNELS-1:0] mm_vld_r;

  logic [TS_W-1:0]  tmax_r;
  logic [IDX_W-1:0] idx_r;
  logic [CH_W-1:0]  ch_r;
  logic [TS_W-1:0]  now_r;
  logic [TS_W-1:0]  start_q_r;
  logic [TS_W-1:0]  min_q_r;
  logic [TS_W-1:0]  max_q_r;
  logic             sv_q_r;
  logic             mm_q_r;
  logic [TS_W-1:0]  span_r;
  logic             out_valid_r;
  out_res_t         out_res_r;

  logic [EXT_W-1:0] ch_ext;
  logic [IDX_W-1:0] in_idx;
  logic             in_range;
  logic             start_hit;
  logic [TS_W-1:0]  start_eff;
  logic [TS_W-1:0]  min_eff;
  logic [TS_W-1:0]  max_eff;
  logic [TS_W-1:0]  span_nxt;
  logic [TS_W-1:0]  min_nxt;
  logic [TS_W-1:0]  max_nxt;
  logic             res_ok;

  assign ch_ext    = {{(EXT_W-CH_W){1'b0}}, in_req.channel};
  assign in_idx    = ch_ext[IDX_W-1:0];
  assign in_range  = ch_ext < EXT_W'(CHANNELS);
  assign start_hit = in_range && (in_req.req_type == REQ_START);

  assign sts.end_hit  = in_range && (in_req.req_type == REQ_END);
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmax_r <= TMAX_RESET;
    end else if (cfg_we) begin
      tmax_r <= cfg_wdata;
    end
  end

  // storage: start written on accept, min/max written at update
  always_ff @(posedge clk) begin
    if (cmd.accept && start_hit) begin
      start_mem[in_idx] <= in_req.timestamp;
    end
    if (cmd.ld_out) begin
      min_mem[idx_r] <= min_nxt;
      max_mem[idx_r] <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      start_q_r <= start_mem[in_idx];
      min_q_r   <= min_mem[in_idx];
      max_q_r   <= max_mem[in_idx];
      sv_q_r    <= sv_vld_r[in_idx];
      mm_q_r    <= mm_vld_r[in_idx];
      idx_r     <= in_idx;
      ch_r      <= in_req.channel;
      now_r     <= in_req.timestamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_vld_r <= '0;
      mm_vld_r <= '0;
    end else begin
      if (cmd.accept && start_hit) begin
        sv_vld_r[in_idx] <= 1'b1;
      end
      if (cmd.ld_out) begin
        mm_vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // unwritten entries read as their reset values
  assign start_eff = sv_q_r ? start_q_r : '0;
  assign min_eff   = mm_q_r ? min_q_r : MIN_RESET;
  assign max_eff   = mm_q_r ? max_q_r : '0;

  // wrap correction, no +1
  assign span_nxt = (now_r < start_eff) ? (tmax_r - start_eff + now_r)
                                        : (now_r - start_eff);

  always_ff @(posedge clk) begin
    if (cmd.ld_span) begin
      span_r <= span_nxt;
    end
  end

  assign min_nxt = (span_r < min_eff) ? span_r : min_eff;
  assign max_nxt = (span_r > max_eff) ? span_r : max_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_res_r.channel_out  <= ch_r;
      out_res_r.interval     <= span_r;
      out_res_r.min_interval <= min_nxt;
      out_res_r.max_interval <= max_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  assign res_ok = (out_res_r.min_interval <= out_res_r.interval) &&
                  (out_res_r.interval <= out_res_r.max_interval);

  // every result brackets its interval
  `AST_IMP(a_res_order, out_valid_r, res_ok)
  `AST_NXT(a_ld_out_valid, cmd.ld_out, out_valid_r)

endmodule

// File: rtl/interval_min_max_profiler.sv
// Per-channel interval profiler. A start request stores its timestamp for the channel; an end
// request computes the elapsed ticks since that start (wrap-corrected against the timer_max
// register, no +1), folds it into the channel's running minimum and maximum and returns one
// result with interval, minimum and maximum. Requests for channels at or above CHANNELS are
// dropped. A start or dropped request completes in the accept step; an end request passes
// through accept with registered storage read, interval subtract and min/max update into the
// result register, waiting in update only while the result register is held by out_stall.
// After reset starts and maxima read 0 and minima read 65535; there is no clearing pass.
`timescale 1ns / 1ps

module interval_min_max_profiler #(
  parameter int CHANNELS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  immp_pkg::in_req_t         in_req,
  output logic                      out_valid,
  input  logic                      out_stall,
  output immp_pkg::out_res_t        out_res,
  input  logic                      cfg_we,
  input  logic [immp_pkg::TS_W-1:0] cfg_wdata
);
  import immp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  immp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  immp_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule
